@@ design/scbs_pkg.sv @@
// Shared types and constants for the six-channel boxcar/IIR smoother.
// No dependencies; every other design file refers to this package by scope.
package scbs_pkg;

  // Defaults for the top-level parameters.
  localparam int WINDOW_LEN_DEFAULT  = 25;
  localparam int CHANNELS_DEFAULT    = 6;
  localparam int SAMPLE_BITS_DEFAULT = 24;

  // Fixed port widths.
  localparam int MAX_CHANNELS      = 6;
  localparam int SAMPLE_FIELD_BITS = 24;
  localparam int POSITION_BITS     = 16;
  localparam int REPORT_BITS       = 17;

  // Values above this limit are reported as zero.
  localparam logic [31:0] REPORT_LIMIT = 32'h0001_ffff;

  // Smoothing weights: out = (SMOOTH_NUM * mean + previous) / SMOOTH_DEN.
  localparam int SMOOTH_NUM = 9;
  localparam int SMOOTH_DEN = 10;

  // Per-cycle controls that the top level hands to every lane.
  typedef struct packed {
    logic take;         // sample set transfer: write ring, update sum
    logic drop_oldest;  // window full: subtract the sample being replaced
    logic adv_b;        // load the mean stage
    logic adv_c;        // load the weighted-mean stage
    logic adv_out;      // update the filter state and the result
    logic first;        // item in the last stage is the first full window
  } lane_ctrl_t;

endpackage

@@ design/scbs_in_if.sv @@
// Sample-set channel: valid/ready handshake with six samples and a position.
// Depends on scbs_pkg for field widths.
interface scbs_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_ch0;
  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_ch1;
  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_ch2;
  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_ch3;
  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_ch4;
  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_ch5;
  logic [scbs_pkg::POSITION_BITS-1:0]     position;

  modport source (
    output valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
           sample_ch5, position,
    input  ready
  );
  modport sink (
    input  valid, sample_ch0, sample_ch1, sample_ch2, sample_ch3, sample_ch4,
           sample_ch5, position,
    output ready
  );
endinterface

@@ design/scbs_out_if.sv @@
// Result channel: valid/ready handshake with six smoothed values and a position.
// Depends on scbs_pkg for field widths.
interface scbs_out_if;
  logic                               valid;
  logic                               ready;
  logic [scbs_pkg::REPORT_BITS-1:0]   smoothed_ch0;
  logic [scbs_pkg::REPORT_BITS-1:0]   smoothed_ch1;
  logic [scbs_pkg::REPORT_BITS-1:0]   smoothed_ch2;
  logic [scbs_pkg::REPORT_BITS-1:0]   smoothed_ch3;
  logic [scbs_pkg::REPORT_BITS-1:0]   smoothed_ch4;
  logic [scbs_pkg::REPORT_BITS-1:0]   smoothed_ch5;
  logic [scbs_pkg::POSITION_BITS-1:0] position_out;

  modport source (
    output valid, smoothed_ch0, smoothed_ch1, smoothed_ch2, smoothed_ch3,
           smoothed_ch4, smoothed_ch5, position_out,
    input  ready
  );
  modport sink (
    input  valid, smoothed_ch0, smoothed_ch1, smoothed_ch2, smoothed_ch3,
           smoothed_ch4, smoothed_ch5, position_out,
    output ready
  );
endinterface

@@ design/six_channel_boxcar_iir_smoother.sv @@
// Top level of the six-channel boxcar/IIR smoother: pipeline control and result merge.
// Depends on scbs_pkg, scbs_in_if, scbs_out_if and scbs_lane.
//
// Usage:
//   samples (sink) takes one sample set per transfer: six unsigned converter
//   samples and a 16-bit encoder position. results (source) gives one result
//   per transfer: six 17-bit smoothed values and the position copied through.
//   Each channel keeps a WINDOW_LEN-deep ring and a running sum. The first
//   WINDOW_LEN-1 sets after reset only fill the window and give no result.
//   The WINDOW_LEN-th set gives the truncated window mean; every later set
//   gives (9*mean + previous)/10, truncated. Values above 0x1ffff are sent as 0.
//   A sample set's transfer edge loads the sum; the mean, the weighting and
//   the smoothing/output registers then load in turn as their stages advance,
//   and the result is valid once the output register has loaded.
//   Throughput: one sample set per cycle unless the receiver stalls; the
//   smoothing loop in each lane closes in one register, the output stage.
//   Reset (rst, synchronous) clears the sums, filter state, ring pointer,
//   warm-up count and all pipeline valids; ring contents are not cleared.
//   When the receiver stalls, the result holds in the output register and the
//   three stages ahead of it keep filling, so up to three more sets transfer
//   before samples.ready drops.
module six_channel_boxcar_iir_smoother #(
  parameter int WINDOW_LEN  = scbs_pkg::WINDOW_LEN_DEFAULT,
  parameter int CHANNELS    = scbs_pkg::CHANNELS_DEFAULT,
  parameter int SAMPLE_BITS = scbs_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic       clk,
  input logic       rst,
  scbs_in_if.sink   samples,
  scbs_out_if.source results
);

  localparam int WARM_BITS = $clog2(WINDOW_LEN);
  localparam logic [WARM_BITS-1:0] WARM_LAST = WARM_BITS'(WINDOW_LEN - 1);

  // Warm-up tracking.
  logic                 active;
  logic [WARM_BITS-1:0] warm;
  logic                 take;
  logic                 emits;

  // Pipeline occupancy: stage a (sum), b (mean), c (weighted mean), then output.
  logic va, vb, vc, ov;
  logic fa, fb, fc;
  logic [scbs_pkg::POSITION_BITS-1:0] pa, pb, pc;
  logic go_out, free_c, adv_c, free_b, adv_b, free_a;

  scbs_pkg::lane_ctrl_t ctl;

  logic [scbs_pkg::SAMPLE_FIELD_BITS-1:0] sample_in [scbs_pkg::MAX_CHANNELS];
  logic [scbs_pkg::REPORT_BITS-1:0]       report    [scbs_pkg::MAX_CHANNELS];
  logic [scbs_pkg::REPORT_BITS-1:0]       out_value [scbs_pkg::MAX_CHANNELS];
  logic [scbs_pkg::POSITION_BITS-1:0]     out_pos;

  // Ready chain: each stage frees up when it is empty or moving on.
  assign go_out = vc && (!ov || results.ready);
  assign free_c = !vc || go_out;
  assign adv_c  = vb && free_c;
  assign free_b = !vb || adv_c;
  assign adv_b  = va && free_b;
  assign free_a = !va || adv_b;

  assign samples.ready = free_a;
  assign take          = samples.valid && samples.ready;
  assign emits         = active || (warm == WARM_LAST);

  assign ctl.take        = take;
  assign ctl.drop_oldest = active;
  assign ctl.adv_b       = adv_b;
  assign ctl.adv_c       = adv_c;
  assign ctl.adv_out     = go_out;
  assign ctl.first       = fc;

  // Warm-up: count sets until the window is full, then smooth from then on.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      warm   <= '0;
    end else if (take && !active) begin
      if (warm == WARM_LAST) begin
        warm   <= '0;
        active <= 1'b1;
      end else begin
        warm <= warm + WARM_BITS'(1);
      end
    end
  end

  // Stage valids; warm-up sets never enter, they only update the sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      vc <= 1'b0;
      ov <= 1'b0;
    end else begin
      if (free_a) va <= take && emits;
      if (free_b) vb <= va;
      if (free_c) vc <= vb;
      if (go_out) begin
        ov <= 1'b1;
      end else if (results.ready) begin
        ov <= 1'b0;
      end
    end
  end

  // Flags and position ride along with the stage valids.
  always_ff @(posedge clk) begin
    if (take) begin
      fa <= !active;
      pa <= samples.position;
    end
    if (adv_b) begin
      fb <= fa;
      pb <= pa;
    end
    if (adv_c) begin
      fc <= fb;
      pc <= pb;
    end
  end

  assign sample_in[0] = samples.sample_ch0;
  assign sample_in[1] = samples.sample_ch1;
  assign sample_in[2] = samples.sample_ch2;
  assign sample_in[3] = samples.sample_ch3;
  assign sample_in[4] = samples.sample_ch4;
  assign sample_in[5] = samples.sample_ch5;

  // One lane per used channel; missing channels report zero.
  for (genvar c = 0; c < scbs_pkg::MAX_CHANNELS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_used
      scbs_lane #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
      ) u_lane (
        .clk    (clk),
        .rst    (rst),
        .ctl    (ctl),
        .sample (sample_in[c][SAMPLE_BITS-1:0]),
        .report (report[c])
      );
    end else begin : g_unused
      assign report[c] = '0;
    end
  end

  // Merge: hold the lane reports and the position until the result transfers.
  always_ff @(posedge clk) begin
    if (go_out) begin
      for (int i = 0; i < scbs_pkg::MAX_CHANNELS; i++) begin
        out_value[i] <= report[i];
      end
      out_pos <= pc;
    end
  end

  assign results.valid        = ov;
  assign results.smoothed_ch0 = out_value[0];
  assign results.smoothed_ch1 = out_value[1];
  assign results.smoothed_ch2 = out_value[2];
  assign results.smoothed_ch3 = out_value[3];
  assign results.smoothed_ch4 = out_value[4];
  assign results.smoothed_ch5 = out_value[5];
  assign results.position_out = out_pos;

  // Once smoothing starts it never stops until reset.
  a_active_sticky: assert property (@(posedge clk) disable iff (rst)
    active |=> active)
    else $error("smoothing flag dropped without reset");

  // The set that completes the window switches to smoothing and rearms the count.
  a_warm_done: assert property (@(posedge clk) disable iff (rst)
    (take && !active && warm == WARM_LAST) |=> (active && warm == '0))
    else $error("warm-up did not complete on the last window set");

  // A first-window item in stage a means smoothing has already been armed.
  a_first_armed: assert property (@(posedge clk) disable iff (rst)
    (va && fa) |-> active)
    else $error("first-window item without smoothing armed");

  // A stalled mean stage keeps its item.
  a_b_holds: assert property (@(posedge clk) disable iff (rst)
    (vb && !adv_c) |=> (vb && $stable(pb)))
    else $error("mean stage lost a stalled item");

endmodule

@@ design/scbs_lane.sv @@
// One channel lane: sample ring, running sum, mean and smoothing datapath.
// Depends on scbs_pkg (lane_ctrl_t, smoothing constants, report limit).
module scbs_lane #(
  parameter int WINDOW_LEN  = scbs_pkg::WINDOW_LEN_DEFAULT,
  parameter int SAMPLE_BITS = scbs_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  scbs_pkg::lane_ctrl_t             ctl,
  input  logic [SAMPLE_BITS-1:0]           sample,
  output logic [scbs_pkg::REPORT_BITS-1:0] report
);

  localparam int SLOT_BITS = $clog2(WINDOW_LEN);
  localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_LEN);

  // Exact divide by WINDOW_LEN: floor(x * ceil(2^k / W) / 2^k) for x < 2^SUM_BITS.
  localparam int MEAN_SHIFT      = SUM_BITS + $clog2(WINDOW_LEN);
  localparam int MEAN_RECIP_BITS = SUM_BITS + 1;
  localparam int MEAN_PROD_BITS  = SUM_BITS + MEAN_RECIP_BITS;
  localparam logic [63:0] MEAN_RECIP_WIDE =
    ((64'd1 << MEAN_SHIFT) + 64'(WINDOW_LEN) - 64'd1) / 64'(WINDOW_LEN);
  localparam logic [MEAN_RECIP_BITS-1:0] MEAN_RECIP = MEAN_RECIP_BITS'(MEAN_RECIP_WIDE);

  // Exact divide by SMOOTH_DEN, same scheme.
  localparam int DEN_BITS       = $clog2(scbs_pkg::SMOOTH_DEN);
  localparam int MIX_BITS       = SAMPLE_BITS + DEN_BITS;
  localparam int MIX_SHIFT      = MIX_BITS + DEN_BITS;
  localparam int MIX_RECIP_BITS = MIX_BITS + 1;
  localparam int MIX_PROD_BITS  = MIX_BITS + MIX_RECIP_BITS;
  localparam logic [63:0] MIX_RECIP_WIDE =
    ((64'd1 << MIX_SHIFT) + 64'(scbs_pkg::SMOOTH_DEN) - 64'd1) / 64'(scbs_pkg::SMOOTH_DEN);
  localparam logic [MIX_RECIP_BITS-1:0] MIX_RECIP = MIX_RECIP_BITS'(MIX_RECIP_WIDE);

  localparam logic [SLOT_BITS-1:0] LAST_SLOT = SLOT_BITS'(WINDOW_LEN - 1);

  logic [SAMPLE_BITS-1:0]    ring [WINDOW_LEN];
  logic [SAMPLE_BITS-1:0]    oldest;
  logic [SLOT_BITS-1:0]      slot;
  logic [SLOT_BITS-1:0]      slot_next;
  logic [SUM_BITS-1:0]       sum;
  logic [SUM_BITS-1:0]       sum_next;
  logic [SUM_BITS-1:0]       a_sum;
  logic [SAMPLE_BITS-1:0]    b_mean;
  logic [SAMPLE_BITS-1:0]    c_mean;
  logic [MIX_BITS-1:0]       c_nine;
  logic [SAMPLE_BITS-1:0]    filter;
  logic [SAMPLE_BITS-1:0]    filter_next;
  logic [MEAN_PROD_BITS-1:0] mean_prod;
  logic [MIX_BITS-1:0]       mix;
  logic [MIX_PROD_BITS-1:0]  mix_prod;
  logic [31:0]               filter_wide;

  assign slot_next = (slot == LAST_SLOT) ? '0 : slot + SLOT_BITS'(1);
  assign sum_next  = sum - (ctl.drop_oldest ? SUM_BITS'(oldest) : '0) + SUM_BITS'(sample);

  // Ring write at the current slot; prefetch the slot that the next set replaces.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      ring[slot] <= sample;
      oldest     <= ring[slot_next];
      a_sum      <= sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= '0;
      sum  <= '0;
    end else if (ctl.take) begin
      slot <= slot_next;
      sum  <= sum_next;
    end
  end

  assign mean_prod = MEAN_PROD_BITS'(a_sum) * MEAN_PROD_BITS'(MEAN_RECIP);

  always_ff @(posedge clk) begin
    if (ctl.adv_b) begin
      b_mean <= mean_prod[MEAN_SHIFT +: SAMPLE_BITS];
    end
    if (ctl.adv_c) begin
      c_mean <= b_mean;
      c_nine <= MIX_BITS'(b_mean) * MIX_BITS'(scbs_pkg::SMOOTH_NUM);
    end
  end

  assign mix         = c_nine + MIX_BITS'(filter);
  assign mix_prod    = MIX_PROD_BITS'(mix) * MIX_PROD_BITS'(MIX_RECIP);
  assign filter_next = ctl.first ? c_mean : mix_prod[MIX_SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      filter <= '0;
    end else if (ctl.adv_out) begin
      filter <= filter_next;
    end
  end

  // Report the new value; anything over the limit goes out as zero.
  assign filter_wide = 32'(filter_next);
  assign report = (filter_wide > scbs_pkg::REPORT_LIMIT) ? '0
                                                         : filter_wide[scbs_pkg::REPORT_BITS-1:0];

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the six-channel boxcar/IIR smoother.
// Depends on scbs_pkg, scbs_in_if, scbs_out_if and the smoother's RTL.
module testbench;

  localparam int          WINDOW       = scbs_pkg::WINDOW_LEN_DEFAULT;
  localparam int          SAMPLE_WIDTH = scbs_pkg::SAMPLE_BITS_DEFAULT;
  localparam int          CHAN_COUNT   = scbs_pkg::MAX_CHANNELS;
  localparam int          FIELD_BITS   = scbs_pkg::SAMPLE_FIELD_BITS;
  localparam int          POS_BITS     = scbs_pkg::POSITION_BITS;
  localparam int          OUT_BITS     = scbs_pkg::REPORT_BITS;
  localparam int unsigned CYCLE_LIMIT  = 200_000;
  localparam int unsigned PIPE_CYCLES  = 8;
  localparam int unsigned PHASE_SETS   = 263;
  localparam int unsigned REGIME_SPAN  = 40;

  // Idle and stall rates per phase, in percent.
  localparam int unsigned SEND_IDLE_PCT  [4] = '{0, 53, 0, 23};
  localparam int unsigned RECV_STALL_PCT [4] = '{0, 0, 53, 23};

  // Value ranges a channel is held in for a stretch of sets.
  typedef enum int unsigned {
    REGIME_LOW,   // zero to 0x3ffff, reaching above the report limit
    REGIME_EDGE,  // straddles the report limit
    REGIME_FULL,  // any 24-bit value
    REGIME_RAIL   // zero or all ones
  } regime_e;

  typedef struct {
    logic [FIELD_BITS-1:0] chan [CHAN_COUNT];
    logic [POS_BITS-1:0]   position;
  } sample_set_t;

  typedef struct {
    logic [OUT_BITS-1:0] smoothed [CHAN_COUNT];
    logic [POS_BITS-1:0] position;
  } smoothed_set_t;

  // Tracks window state per channel and holds the smoothed sets still owed.
  class smoothing_scoreboard;
    logic [FIELD_BITS-1:0] ring [CHAN_COUNT][WINDOW];
    logic [28:0]           window_sum [CHAN_COUNT];
    logic [FIELD_BITS-1:0] smoothed_state [CHAN_COUNT];
    int unsigned           slot;
    int unsigned           fill_count;
    bit                    smoothing;
    smoothed_set_t         owed [$];
    int unsigned           error_count;

    function new();
      foreach (ring[c, i]) ring[c][i] = '0;
      foreach (window_sum[c]) begin
        window_sum[c]     = '0;
        smoothed_state[c] = '0;
      end
      slot        = 0;
      fill_count  = 0;
      smoothing   = 1'b0;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction

    // Advance the windows by one sample set; queue a result once the window is full.
    function void note_sample_set(sample_set_t s);
      smoothed_set_t         r;
      logic [FIELD_BITS-1:0] v;
      int unsigned           mean;
      for (int c = 0; c < CHAN_COUNT; c++) begin
        v = s.chan[c] & FIELD_BITS'((64'd1 << SAMPLE_WIDTH) - 1);
        if (smoothing) window_sum[c] -= 29'(ring[c][slot]);
        window_sum[c] += 29'(v);
        ring[c][slot] = v;
      end
      slot = (slot + 1 >= WINDOW) ? 0 : slot + 1;

      if (!smoothing) begin
        fill_count++;
        if (fill_count < WINDOW) return;
        // First full window: plain mean, no weighting.
        for (int c = 0; c < CHAN_COUNT; c++)
          smoothed_state[c] = FIELD_BITS'(int'(window_sum[c]) / WINDOW);
        fill_count = 0;
        smoothing  = 1'b1;
      end else begin
        for (int c = 0; c < CHAN_COUNT; c++) begin
          mean = int'(window_sum[c]) / WINDOW;
          smoothed_state[c] = FIELD_BITS'(
              (scbs_pkg::SMOOTH_NUM * mean + int'(smoothed_state[c]))
              / scbs_pkg::SMOOTH_DEN);
        end
      end

      for (int c = 0; c < CHAN_COUNT; c++)
        r.smoothed[c] = (32'(smoothed_state[c]) > scbs_pkg::REPORT_LIMIT) ?
                        '0 : smoothed_state[c][OUT_BITS-1:0];
      r.position = s.position;
      owed.push_back(r);
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("ERROR @%0t: %s", $time, what);
    endtask

    task check_result(smoothed_set_t got);
      smoothed_set_t want;
      if (owed.size() == 0) begin
        report_mismatch("result transfer with nothing owed");
        return;
      end
      want = owed.pop_front();
      for (int c = 0; c < CHAN_COUNT; c++)
        if (got.smoothed[c] !== want.smoothed[c])
          report_mismatch($sformatf("smoothed_ch%0d got %h, want %h",
                                    c, got.smoothed[c], want.smoothed[c]));
      if (got.position !== want.position)
        report_mismatch($sformatf("position_out got %h, want %h",
                                  got.position, want.position));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count    = 0;

  smoothing_scoreboard sb = new();

  scbs_in_if  samples_if ();
  scbs_out_if results_if ();

  six_channel_boxcar_iir_smoother uut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up if the run stalls; a correct run ends far below this.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("six_channel_boxcar_iir_smoother: mismatch");
      $finish;
    end
  end

  // Drop results.ready at random while a stall rate is set; hold it low in reset.
  initial results_if.ready = 1'b0;
  always @(negedge clk) begin
    if (rst) results_if.ready <= 1'b0;
    else     results_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Watch both channels at the rising edge: feed each sample transfer to the
  // predictor and check each result transfer against the oldest owed set.
  always @(posedge clk) begin : watch_transfers
    sample_set_t   seen_set;
    smoothed_set_t seen_result;
    if (!rst) begin
      if (samples_if.valid && samples_if.ready) begin
        seen_set.chan[0]  = samples_if.sample_ch0;
        seen_set.chan[1]  = samples_if.sample_ch1;
        seen_set.chan[2]  = samples_if.sample_ch2;
        seen_set.chan[3]  = samples_if.sample_ch3;
        seen_set.chan[4]  = samples_if.sample_ch4;
        seen_set.chan[5]  = samples_if.sample_ch5;
        seen_set.position = samples_if.position;
        sb.note_sample_set(seen_set);
      end
      if (results_if.valid && results_if.ready) begin
        seen_result.smoothed[0] = results_if.smoothed_ch0;
        seen_result.smoothed[1] = results_if.smoothed_ch1;
        seen_result.smoothed[2] = results_if.smoothed_ch2;
        seen_result.smoothed[3] = results_if.smoothed_ch3;
        seen_result.smoothed[4] = results_if.smoothed_ch4;
        seen_result.smoothed[5] = results_if.smoothed_ch5;
        seen_result.position    = results_if.position_out;
        sb.check_result(seen_result);
      end
    end
  end

  // Offer one sample set, starting and ending at a falling edge. Idle first
  // at the current sender rate, then hold valid until the transfer happens.
  task automatic send_sample_set(input sample_set_t s);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      samples_if.valid <= 1'b0;
      @(negedge clk);
    end
    samples_if.valid      <= 1'b1;
    samples_if.sample_ch0 <= s.chan[0];
    samples_if.sample_ch1 <= s.chan[1];
    samples_if.sample_ch2 <= s.chan[2];
    samples_if.sample_ch3 <= s.chan[3];
    samples_if.sample_ch4 <= s.chan[4];
    samples_if.sample_ch5 <= s.chan[5];
    samples_if.position   <= s.position;
    do @(posedge clk); while (!samples_if.ready);
    @(negedge clk);
  endtask

  // Stop sending and wait until every owed result has transferred.
  task automatic wait_for_drain();
    samples_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  function automatic logic [FIELD_BITS-1:0] pick_sample(regime_e regime);
    case (regime)
      REGIME_LOW:  return FIELD_BITS'($urandom_range(0, 'h3ffff));
      REGIME_EDGE: return FIELD_BITS'($urandom_range('h1fe00, 'h20200));
      REGIME_FULL: return FIELD_BITS'($urandom());
      default:     return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // Directed window: most channels sit on an extreme or on the limit so the first mean and
  // the weighted follow-up land on known spots around the report limit.
  function automatic sample_set_t directed_set(int unsigned k);
    sample_set_t s;
    bit          swap;
    swap      = (k >= WINDOW);
    s.chan[0] = swap ? 24'hffffff : 24'h000000;
    s.chan[1] = swap ? 24'h000000 : 24'hffffff;
    s.chan[2] = 24'h01ffff;                        // mean sits right at the limit
    s.chan[3] = swap ? 24'h01ffff : 24'h020000;    // just above, then back down
    s.chan[4] = k[0] ? 24'haaaaaa : 24'h555555;
    s.chan[5] = 24'(k * 'h0aaaab);
    s.position = k[0] ? 16'hffff : 16'(k);
    return s;
  endfunction

  initial begin : stimulus
    sample_set_t s;
    regime_e     regime [CHAN_COUNT];
    samples_if.valid      = 1'b0;
    samples_if.sample_ch0 = '0;
    samples_if.sample_ch1 = '0;
    samples_if.sample_ch2 = '0;
    samples_if.sample_ch3 = '0;
    samples_if.sample_ch4 = '0;
    samples_if.sample_ch5 = '0;
    samples_if.position   = '0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Fill the window with extremes, then push the weighted path past it.
    for (int unsigned k = 0; k < WINDOW + 5; k++)
      send_sample_set(directed_set(k));
    wait_for_drain();

    // Random phases, each with its own idle and stall rates. Hold every
    // channel in one value range for a stretch so the smoothed output can
    // settle near, above or below the report limit.
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      for (int unsigned n = 0; n < PHASE_SETS; n++) begin
        if (n % REGIME_SPAN == 0)
          foreach (regime[c]) regime[c] = regime_e'($urandom_range(0, 3));
        foreach (s.chan[c]) s.chan[c] = pick_sample(regime[c]);
        s.position = POS_BITS'($urandom());
        send_sample_set(s);
      end
      // Pause the sender until the result side has caught up.
      wait_for_drain();
    end

    // Let the pipeline run dry so a stray extra result would still be seen.
    repeat (PIPE_CYCLES) @(negedge clk);
    if (sb.error_count == 0 && sb.pending() == 0)
      $display("six_channel_boxcar_iir_smoother: match");
    else
      $display("six_channel_boxcar_iir_smoother: mismatch");
    $finish;
  end
endmodule
